/* src/sha_pkg.sv */
// Package for the SHA-256 byte stream hasher: round constants, initial hash values,
// the front-to-back queue entry type and the round helper functions.
// No dependencies.
package sha_pkg;

    localparam int unsigned QueueDepth = 4;
    localparam logic [7:0] PadByte = 8'h80;
    localparam logic [6:0] LenStart = 7'd56;

    typedef enum logic {
        CMD_ABSORB = 1'b0,
        CMD_FINISH = 1'b1
    } cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] data_byte;
    } entry_t;

    localparam logic [31:0] InitH [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam logic [31:0] RoundK [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction

    function automatic logic [31:0] sig0(input logic [31:0] w);
        sig0 = rotr(w, 7) ^ rotr(w, 18) ^ (w >> 3);
    endfunction

    function automatic logic [31:0] sig1(input logic [31:0] w);
        sig1 = rotr(w, 17) ^ rotr(w, 19) ^ (w >> 10);
    endfunction

endpackage

/* src/sha_queue.sv */
// Small FIFO that decouples command intake from the compression engine.
// Depends on sha_pkg for the entry type.
module sha_queue #(
    parameter int unsigned DEPTH = sha_pkg::QueueDepth
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  sha_pkg::entry_t wr_data,
    output logic            rd_valid,
    input  logic            rd_ready,
    output sha_pkg::entry_t rd_data
);
    import sha_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    entry_t         mem_reg [DEPTH];
    logic [AW-1:0]  wptr_reg, rptr_reg;
    logic [AW:0]    count_reg;

    logic do_wr, do_rd;

    assign wr_ready = (count_reg != (AW+1)'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wptr_reg] <= wr_data;
        end
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (do_wr) begin
                wptr_reg <= (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (do_rd) begin
                rptr_reg <= (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            count_reg <= count_reg + (AW+1)'(do_wr) - (AW+1)'(do_rd);
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (AW+1)'(DEPTH))
        else $error("queue count beyond depth");
    a_full_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == (AW+1)'(DEPTH)) |-> !wr_ready)
        else $error("queue full but writable");
    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_wr && !do_rd) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not grow");
endmodule

/* src/sha_engine.sv */
// Back end: buffers bytes, pads, runs the 64-round compression one round per cycle
// and streams out the digest words. Depends on sha_pkg.
module sha_engine (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    output logic            q_ready,
    input  sha_pkg::entry_t q_data,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [31:0]     m_digest_word,
    output logic [2:0]      m_word_index,
    output logic            m_last_word
);
    import sha_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PAD   = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_FOLD  = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t       state_reg;
    logic [31:0]  chain_reg [8];
    logic [31:0]  wrk_reg [8];
    logic [31:0]  w_reg [16];
    logic [5:0]   fill_reg;
    logic [63:0]  bits_reg;
    logic [5:0]   round_reg;
    logic         final_reg;   // block being compressed is the last of the message
    logic         extra_reg;   // a length-only block still follows
    logic [2:0]   widx_reg;

    logic [31:0]  wt, t1, t2, snew;
    logic [1:0]   bpos;
    logic [3:0]   wsel;

    assign bpos = fill_reg[1:0];
    assign wsel = fill_reg[5:2];

    // Message schedule: the first sixteen words come from the shift buffer; later
    // words are built in place from the rolling window.
    assign snew = sig1(w_reg[14]) + w_reg[9] + sig0(w_reg[1]) + w_reg[0];
    assign wt   = (round_reg < 6'd16) ? w_reg[0] : snew;
    assign t1 = wrk_reg[7] + (rotr(wrk_reg[4], 6) ^ rotr(wrk_reg[4], 11) ^
                rotr(wrk_reg[4], 25)) + ((wrk_reg[4] & wrk_reg[5]) ^
                (~wrk_reg[4] & wrk_reg[6])) + RoundK[round_reg] + wt;
    assign t2 = (rotr(wrk_reg[0], 2) ^ rotr(wrk_reg[0], 13) ^ rotr(wrk_reg[0], 22)) +
                ((wrk_reg[0] & wrk_reg[1]) ^ (wrk_reg[0] & wrk_reg[2]) ^
                (wrk_reg[1] & wrk_reg[2]));

    assign q_ready       = (state_reg == ST_IDLE);
    assign m_valid       = (state_reg == ST_EMIT);
    assign m_digest_word = chain_reg[widx_reg];
    assign m_word_index  = widx_reg;
    assign m_last_word   = (widx_reg == 3'd7);

    // Byte write into the word buffer: w_reg[wsel] lane bpos, big-endian.
    function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [1:0] p,
                                             input logic [7:0] b);
        logic [31:0] r;
        r = w;
        r[8*(3-p) +: 8] = b;
        put_byte = r;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            bits_reg  <= '0;
            round_reg <= '0;
            final_reg <= 1'b0;
            extra_reg <= 1'b0;
            widx_reg  <= '0;
            for (int i = 0; i < 8; i++) chain_reg[i] <= InitH[i];
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        if (q_data.cmd == CMD_ABSORB) begin
                            w_reg[wsel] <= put_byte(w_reg[wsel], bpos, q_data.data_byte);
                            bits_reg <= bits_reg + 64'd8;
                            fill_reg <= fill_reg + 1'b1;
                            if (fill_reg == 6'd63) begin
                                final_reg <= 1'b0;
                                round_reg <= '0;
                                for (int i = 0; i < 8; i++) wrk_reg[i] <= chain_reg[i];
                                state_reg <= ST_ROUND;
                            end
                        end else begin
                            w_reg[wsel] <= put_byte(w_reg[wsel], bpos, PadByte);
                            fill_reg  <= fill_reg + 1'b1;
                            extra_reg <= ({1'b0, fill_reg} >= LenStart);
                            state_reg <= ST_PAD;
                        end
                    end
                end
                ST_PAD: begin
                    // One zero byte a cycle until the block or the length field is reached.
                    if ((extra_reg && fill_reg == 6'd0) ||
                        (!extra_reg && {1'b0, fill_reg} == LenStart)) begin
                        if (!extra_reg) begin
                            w_reg[14] <= bits_reg[63:32];
                            w_reg[15] <= bits_reg[31:0];
                            final_reg <= 1'b1;
                        end else begin
                            final_reg <= 1'b0;
                        end
                        round_reg <= '0;
                        for (int i = 0; i < 8; i++) wrk_reg[i] <= chain_reg[i];
                        state_reg <= ST_ROUND;
                    end else begin
                        w_reg[wsel] <= put_byte(w_reg[wsel], bpos, 8'h00);
                        fill_reg <= fill_reg + 1'b1;
                    end
                end
                ST_ROUND: begin
                    for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
                    w_reg[15] <= wt;
                    wrk_reg[7] <= wrk_reg[6];
                    wrk_reg[6] <= wrk_reg[5];
                    wrk_reg[5] <= wrk_reg[4];
                    wrk_reg[4] <= wrk_reg[3] + t1;
                    wrk_reg[3] <= wrk_reg[2];
                    wrk_reg[2] <= wrk_reg[1];
                    wrk_reg[1] <= wrk_reg[0];
                    wrk_reg[0] <= t1 + t2;
                    round_reg  <= round_reg + 1'b1;
                    if (round_reg == 6'd63) begin
                        state_reg <= ST_FOLD;
                    end
                end
                ST_FOLD: begin
                    for (int i = 0; i < 8; i++) chain_reg[i] <= chain_reg[i] + wrk_reg[i];
                    fill_reg <= '0;
                    if (final_reg) begin
                        widx_reg  <= '0;
                        state_reg <= ST_EMIT;
                    end else if (extra_reg) begin
                        extra_reg <= 1'b0;
                        state_reg <= ST_PAD;
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_EMIT: begin
                    if (m_ready) begin
                        widx_reg <= widx_reg + 1'b1;
                        if (widx_reg == 3'd7) begin
                            for (int i = 0; i < 8; i++) chain_reg[i] <= InitH[i];
                            bits_reg  <= '0;
                            final_reg <= 1'b0;
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("state register not one-hot");
    a_round_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND && round_reg == 6'd63) |=> state_reg == ST_FOLD)
        else $error("compression did not end after round 63");
    a_emit_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_word) |=> (state_reg == ST_IDLE && bits_reg == '0))
        else $error("state not restored after digest");
endmodule

/* src/sha256_byte_stream_hasher.sv */
// SHA-256 byte stream hasher, top level: intake queue plus compression engine.
// Depends on sha_pkg, sha_queue and sha_engine.
//
// Each input transaction is either a message byte (s_cmd = 0) or a finish
// command (s_cmd = 1). Bytes enter a short queue and are absorbed by the engine
// at one byte per cycle while it is idle; the 64th byte of a block starts the
// compression, which runs one round per cycle and then a fold step, and no byte
// is taken until the block is done. The single round unit sets the sustained
// rate. A finish pads one byte per cycle, compresses one block (two when more
// than 55 bytes were buffered), then presents the digest as eight result
// transactions, word 0 first, with m_last_word on word 7. After the last word
// is taken the hasher is back to its initial state for the next message. The
// queue lets upstream keep sending while a block compresses, until it is full.
module sha256_byte_stream_hasher #(
    parameter int unsigned QUEUE_DEPTH = sha_pkg::QueueDepth
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word
);
    import sha_pkg::*;

    entry_t in_entry, q_entry;
    logic   q_valid, q_ready;

    // The front end classifies the raw command bit into the command code.
    assign in_entry.cmd       = s_cmd ? CMD_FINISH : CMD_ABSORB;
    assign in_entry.data_byte = s_data_byte;

    sha_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_valid),
        .wr_ready (s_ready),
        .wr_data  (in_entry),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_entry)
    );

    sha_engine u_engine (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_data        (q_entry),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_digest_word (m_digest_word),
        .m_word_index  (m_word_index),
        .m_last_word   (m_last_word)
    );

    a_last_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_word == (m_word_index == 3'd7)))
        else $error("last flag does not match word index");
    a_idx_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_word) |=> (m_valid &&
        m_word_index == $past(m_word_index) + 3'd1))
        else $error("digest words out of sequence");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_digest_word)))
        else $error("result changed while stalled");
endmodule
